>>> hw/rtl/fdtd_1d_field_update_macros.svh
// Assertion macros for the one-dimensional FDTD field update block.
// Depends on nothing; the including module must have i_clk and i_rst_n.
`ifndef FDTD_1D_FIELD_UPDATE_MACROS_SVH
`define FDTD_1D_FIELD_UPDATE_MACROS_SVH

// Checked on every rising edge outside of reset.
`define FDTD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define FDTD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

>>> hw/rtl/fdtd1d_pkg.sv
// Shared types and constants of the one-dimensional FDTD field update block.
// Depends on nothing; used by the cell, the update pipeline and the top level.
package fdtd1d_pkg;

    // One grid cell as it travels around the ring.
    typedef struct packed {
        logic signed [31:0] e;
        logic signed [31:0] h;
        logic signed [31:0] d;
        logic        [16:0] inv;
        logic signed [31:0] p;
    } t_cell;

    // Per-word control that travels with a cell through the update pipeline.
    typedef struct packed {
        logic valid;
        logic first;
    } t_ctrl;

    localparam logic [16:0] INV_EPS_ONE  = 17'd65536;
    localparam logic [16:0] COURANT_INIT = 17'd32768;
    localparam logic [19:0] FOUR_PI_Q16  = 20'd823550;

    localparam t_cell CELL_RESET = '{e: 32'sd0, h: 32'sd0, d: 32'sd0,
                                     inv: INV_EPS_ONE, p: 32'sd0};

    // Depth of the update pipeline that closes the ring.
    localparam int PIPE_DEPTH = 6;

    // Medium modes; any other code behaves as vacuum.
    localparam logic [1:0] MODE_VACUUM = 2'd0;
    localparam logic [1:0] MODE_DIEL   = 2'd1;
    localparam logic [1:0] MODE_POLAR  = 2'd2;

    // Commands.
    localparam logic [1:0] CMD_WR_FIELDS   = 2'd0;
    localparam logic [1:0] CMD_WR_MATERIAL = 2'd1;
    localparam logic [1:0] CMD_READ        = 2'd2;
    localparam logic [1:0] CMD_STEP        = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_COURANT = 2'd0;
    localparam logic [1:0] REG_MODE    = 2'd1;

endpackage

>>> hw/rtl/fdtd1d_cell.sv
// One storage cell of the field ring: holds a grid cell and passes it on.
// Depends on fdtd1d_pkg for the cell record and its reset value.
module fdtd1d_cell
    import fdtd1d_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_cell i_d,
    output t_cell o_q
);

    t_cell r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= CELL_RESET;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

>>> hw/rtl/fdtd1d_pipe.sv
// Six-stage Yee update pipeline that closes the field ring.
// Depends on fdtd1d_pkg for the cell record, control word and constants.
module fdtd1d_pipe
    import fdtd1d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_step,
    input  logic [1:0]         i_mode,
    input  logic [16:0]        i_k,
    input  t_cell              i_rec,
    input  logic signed [31:0] i_e_next,
    input  t_ctrl              i_ctrl,
    output t_cell              o_rec,
    output logic               o_sat
);

    typedef struct packed {
        logic               hit;
        logic signed [31:0] v;
    } t_sat;

    // Round a Q32.32 product to Q16.16, half up.
    function automatic logic signed [39:0] rnd_q16(input logic signed [55:0] x);
        logic signed [55:0] s;
        s = x + 56'sd32768;
        return s[55:16];
    endfunction

    function automatic t_sat sat32(input logic signed [39:0] x);
        t_sat r;
        r.hit = (x > 40'sd2147483647) || (x < -40'sd2147483648);
        if (x > 40'sd2147483647) begin
            r.v = 32'sh7fffffff;
        end else if (x < -40'sd2147483648) begin
            r.v = 32'sh80000000;
        end else begin
            r.v = x[31:0];
        end
        return r;
    endfunction

    logic w_vacuum;
    assign w_vacuum = (i_mode != MODE_DIEL) && (i_mode != MODE_POLAR);

    t_cell r1_rec, r2_rec, r3_rec, r4_rec, r5_rec, r6_rec;
    t_cell n2_rec, n4_rec, n6_rec;
    t_ctrl r1_ctrl, r2_ctrl, r3_ctrl, r4_ctrl, r5_ctrl;
    logic signed [50:0] r1_prod_h, n1_prod_h;
    logic signed [50:0] r3_prod_x, n3_prod_x;
    logic signed [49:0] r5_prod_e, n5_prod_e;
    logic signed [52:0] r5_prod_p, n5_prod_p;
    logic signed [32:0] w_diff_h, w_diff_x;
    logic signed [31:0] w_h_prev, w_x_old;
    t_sat w_h_new, w_x_new, w_e_diel, w_e_pol;
    logic w_upd2, w_upd4, w_upd6;

    // Stage 1: k times the forward E difference.
    assign w_diff_h  = 33'(i_e_next) - 33'(i_rec.e);
    assign n1_prod_h = w_diff_h * $signed({1'b0, i_k});

    // Stage 2: new H.
    assign w_upd2  = i_step && r1_ctrl.valid;
    assign w_h_new = sat32(40'(r1_rec.h) - rnd_q16(56'(r1_prod_h)));
    always_comb begin
        n2_rec = r1_rec;
        if (w_upd2) begin
            n2_rec.h = w_h_new.v;
        end
    end

    // Stage 3: k times the backward H difference; stage 3 still holds the
    // previous cell's new H, and there is no H before the first cell.
    assign w_h_prev  = r2_ctrl.first ? 32'sd0 : r3_rec.h;
    assign w_diff_x  = 33'(r2_rec.h) - 33'(w_h_prev);
    assign n3_prod_x = w_diff_x * $signed({1'b0, i_k});

    // Stage 4: new E in vacuum, new D otherwise.
    assign w_upd4  = i_step && r3_ctrl.valid;
    assign w_x_old = w_vacuum ? r3_rec.e : r3_rec.d;
    assign w_x_new = sat32(40'(w_x_old) - rnd_q16(56'(r3_prod_x)));
    always_comb begin
        n4_rec = r3_rec;
        if (w_upd4) begin
            if (w_vacuum) begin
                n4_rec.e = w_x_new.v;
            end else begin
                n4_rec.d = w_x_new.v;
            end
        end
    end

    // Stage 5: material products.
    assign n5_prod_e = r4_rec.d * $signed({1'b0, r4_rec.inv});
    assign n5_prod_p = r4_rec.p * $signed({1'b0, FOUR_PI_Q16});

    // Stage 6: E from D.
    assign w_upd6   = i_step && r5_ctrl.valid;
    assign w_e_diel = sat32(rnd_q16(56'(r5_prod_e)));
    assign w_e_pol  = sat32(40'(r5_rec.d) - rnd_q16(56'(r5_prod_p)));
    always_comb begin
        n6_rec = r5_rec;
        if (w_upd6 && i_mode == MODE_DIEL) begin
            n6_rec.e = w_e_diel.v;
        end else if (w_upd6 && i_mode == MODE_POLAR) begin
            n6_rec.e = w_e_pol.v;
        end
    end

    assign o_sat = (w_upd2 && w_h_new.hit) || (w_upd4 && w_x_new.hit)
                || (w_upd6 && i_mode == MODE_DIEL && w_e_diel.hit)
                || (w_upd6 && i_mode == MODE_POLAR && w_e_pol.hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctrl <= '0;
            r2_ctrl <= '0;
            r3_ctrl <= '0;
            r4_ctrl <= '0;
            r5_ctrl <= '0;
        end else if (i_en) begin
            r1_ctrl <= i_ctrl;
            r2_ctrl <= r1_ctrl;
            r3_ctrl <= r2_ctrl;
            r4_ctrl <= r3_ctrl;
            r5_ctrl <= r4_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_rec    <= i_rec;
            r1_prod_h <= n1_prod_h;
            r2_rec    <= n2_rec;
            r3_rec    <= r2_rec;
            r3_prod_x <= n3_prod_x;
            r4_rec    <= n4_rec;
            r5_rec    <= r4_rec;
            r5_prod_e <= n5_prod_e;
            r5_prod_p <= n5_prod_p;
            r6_rec    <= n6_rec;
        end
    end

    assign o_rec = r6_rec;

endmodule

>>> hw/rtl/fdtd_1d_field_update.sv
// Top level of the one-dimensional FDTD field update block: a ring of grid
// cells closed by the update pipeline. Depends on fdtd1d_pkg, fdtd1d_cell,
// fdtd1d_pipe and fdtd_1d_field_update_macros.svh.
//
//  channel   | direction | handshake                    | word
//  ----------+-----------+------------------------------+----------------------------------
//  command   | in        | start high while busy low    | cmd, cell_index, field values
//  result    | out       | o_valid, one cycle, no stall | index, E, H, D, saturated
//  config    | in        | i_cfg_we, taken at once      | i_cfg_index, i_cfg_wdata
//
// Every command takes one full turn of the ring (the ring is CELLS cells plus
// six pipeline stages), and its result word shows in the first cycle with
// busy low, when the next command may already start. The ring shifts one
// cell per cycle while busy.
// Reset is synchronous and clears every cell at once, so no clearing pass.
// The receiver cannot stall: a result word is shown for exactly one cycle.
`include "fdtd_1d_field_update_macros.svh"

module fdtd_1d_field_update
    import fdtd1d_pkg::*;
#(
    parameter int CELLS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic [9:0]         i_cell_index,
    input  logic signed [31:0] i_e_value,
    input  logic signed [31:0] i_h_value,
    input  logic signed [31:0] i_d_value,
    input  logic [16:0]        i_inv_eps_value,
    input  logic signed [31:0] i_pol_value,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_wdata,
    output logic               o_valid,
    output logic [9:0]         o_out_index,
    output logic signed [31:0] o_e_out,
    output logic signed [31:0] o_h_out,
    output logic signed [31:0] o_d_out,
    output logic               o_saturated
);

    localparam int CNT_W = $clog2(CELLS + PIPE_DEPTH);
    localparam int CMP_W = (CNT_W > 10) ? CNT_W : 10;
    localparam logic [CNT_W-1:0] N_CELLS    = CNT_W'(CELLS);
    localparam logic [CNT_W-1:0] LAST_CELL  = CNT_W'(CELLS - 1);
    localparam logic [CNT_W-1:0] LAST_SHIFT = CNT_W'(CELLS + PIPE_DEPTH - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [16:0]      r_k;
    logic [1:0]       r_mode;
    logic             r_sat, n_sat;
    logic             r_out_valid;

    // Latched command word.
    logic [1:0]         r_cmd;
    logic [9:0]         r_idx;
    logic signed [31:0] r_e_in, r_h_in, r_d_in, r_p_in;
    logic [16:0]        r_inv_in;

    // Addressed cell as seen after the command's write.
    logic signed [31:0] r_cap_e, r_cap_h, r_cap_d;

    logic [9:0]         r_out_index;
    logic signed [31:0] r_out_e, r_out_h, r_out_d;
    logic               r_out_sat;

    logic               w_run, w_step, w_last, w_entry_valid, w_match, w_pipe_sat;
    t_cell              w_q [CELLS];
    t_cell              w_entry, w_pipe_out;
    t_ctrl              w_ctrl;
    logic signed [31:0] w_e_next;

    assign busy   = (r_state == ST_RUN);
    assign w_run  = (r_state == ST_RUN);
    assign w_step = (r_cmd == CMD_STEP);
    assign w_last = (r_cnt == LAST_SHIFT);

    // The ring turns once per command. Cell r_cnt sits at the head while
    // r_cnt is below CELLS; after that the pipeline's empty slots go by.
    assign w_entry_valid = (r_cnt < N_CELLS);
    assign w_match = w_entry_valid && (CMP_W'(r_cnt) == CMP_W'(r_idx));
    assign w_ctrl.valid = w_entry_valid;
    assign w_ctrl.first = (r_cnt == '0);

    // E beyond the last cell is zero; otherwise the next cell is right
    // behind the head, still holding its old E.
    assign w_e_next = (r_cnt < LAST_CELL) ? w_q[1].e : 32'sd0;

    // Writes are merged into the cell as it leaves the head.
    always_comb begin
        w_entry = w_q[0];
        if (w_match && r_cmd == CMD_WR_FIELDS) begin
            w_entry.e = r_e_in;
            w_entry.h = r_h_in;
            w_entry.d = r_d_in;
        end else if (w_match && r_cmd == CMD_WR_MATERIAL) begin
            w_entry.inv = r_inv_in;
            w_entry.p   = r_p_in;
        end
    end

    for (genvar gp = 0; gp < CELLS; gp++) begin : g_ring
        t_cell w_d;
        if (gp == CELLS - 1) begin : g_tail
            assign w_d = w_pipe_out;
        end else begin : g_body
            assign w_d = w_q[gp + 1];
        end
        fdtd1d_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_run),
            .i_d     (w_d),
            .o_q     (w_q[gp])
        );
    end

    fdtd1d_pipe u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_run),
        .i_step   (w_step),
        .i_mode   (r_mode),
        .i_k      (r_k),
        .i_rec    (w_entry),
        .i_e_next (w_e_next),
        .i_ctrl   (w_ctrl),
        .o_rec    (w_pipe_out),
        .o_sat    (w_pipe_sat)
    );

    // The last update that can clamp is checked before the final shift, so
    // the flag is complete when the result is loaded.
    assign n_sat = r_sat | (w_run & w_pipe_sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_k         <= COURANT_INIT;
            r_mode      <= MODE_VACUUM;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_COURANT) begin
                r_k <= i_cfg_wdata;
            end else if (i_cfg_we && i_cfg_index == REG_MODE) begin
                r_mode <= i_cfg_wdata[1:0];
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_out_valid <= 1'b0;
                    if (start) begin
                        r_state <= ST_RUN;
                        r_cnt   <= '0;
                    end
                end
                ST_RUN: begin
                    // A step hands its flag to the result word and starts afresh.
                    r_sat       <= (w_last && w_step) ? 1'b0 : n_sat;
                    r_out_valid <= w_last;
                    if (w_last) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state     <= ST_IDLE;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd    <= i_cmd;
            r_idx    <= i_cell_index;
            r_e_in   <= i_e_value;
            r_h_in   <= i_h_value;
            r_d_in   <= i_d_value;
            r_inv_in <= i_inv_eps_value;
            r_p_in   <= i_pol_value;
            r_cap_e  <= 32'sd0;
            r_cap_h  <= 32'sd0;
            r_cap_d  <= 32'sd0;
        end else if (w_run && w_match && !w_step) begin
            r_cap_e <= w_entry.e;
            r_cap_h <= w_entry.h;
            r_cap_d <= w_entry.d;
        end
        if (w_run && w_last) begin
            // A step reports no cell; an index outside the grid never
            // matches, so its fields stay at the zero loaded on accept.
            r_out_index <= w_step ? 10'd0 : r_idx;
            r_out_e     <= r_cap_e;
            r_out_h     <= r_cap_h;
            r_out_d     <= r_cap_d;
            r_out_sat   <= n_sat;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_e_out     = r_out_e;
    assign o_h_out     = r_out_h;
    assign o_d_out     = r_out_d;
    assign o_saturated = r_out_sat;

    `FDTD_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !busy && !o_valid, "reset left block busy")
    `FDTD_ASSERT(a_start_runs, start && !busy |=> busy, "accepted command did not start")
    `FDTD_ASSERT(a_cnt_range, busy |-> r_cnt <= LAST_SHIFT, "ring counter overran")
    `FDTD_ASSERT(a_result_after_run, o_valid |-> $past(busy) && !busy, "result without a turn")
    `FDTD_ASSERT(a_step_clears, o_valid && w_step |-> !r_sat && o_out_index == '0, "flag kept")

endmodule
